[rtl/core/fsfc_pkg.sv]
// shared types, widths and constants of the flat shading face color block
package fsfc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int SEDGE_MAG_W = 25;
  localparam int SEDGE_W     = SEDGE_MAG_W + 1;
  localparam int PROD_W      = 2 * SEDGE_MAG_W + 1;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int CMAG_W      = CROSS_W - 1;
  localparam int M_W         = 31;
  localparam int SQ_W        = 2 * M_W;
  localparam int SUM_W       = 64;
  localparam int LEN_W       = SUM_W / 2;
  localparam int NORM_SHIFT  = 14;
  localparam int Q_W         = NORM_SHIFT + 1;
  localparam int NUM_W       = M_W + NORM_SHIFT + 1;
  localparam int REM_W       = NUM_W + 1;
  localparam int SH_W        = 6;

  localparam logic [15:0] LEVEL_ONE = 16'd32768;

  localparam logic [2:0] CFG_LIGHT_X    = 3'd0;
  localparam logic [2:0] CFG_LIGHT_Y    = 3'd1;
  localparam logic [2:0] CFG_LIGHT_Z    = 3'd2;
  localparam logic [2:0] CFG_AMBIENT    = 3'd3;
  localparam logic [2:0] CFG_DIFFUSE    = 3'd4;
  localparam logic [2:0] CFG_BASE_COLOR = 3'd5;

  localparam logic [15:0] RST_LIGHT_X    = 16'd9459;
  localparam logic [15:0] RST_LIGHT_Y    = 16'd9459;
  localparam logic [15:0] RST_LIGHT_Z    = 16'hDB0D;
  localparam logic [15:0] RST_AMBIENT    = 16'd8192;
  localparam logic [15:0] RST_DIFFUSE    = 16'd24576;
  localparam logic [23:0] RST_BASE_COLOR = 24'd14464140;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] corner0_x;
    logic signed [COORD_WIDTH-1:0] corner0_y;
    logic signed [COORD_WIDTH-1:0] corner0_z;
    logic signed [COORD_WIDTH-1:0] corner1_x;
    logic signed [COORD_WIDTH-1:0] corner1_y;
    logic signed [COORD_WIDTH-1:0] corner1_z;
    logic signed [COORD_WIDTH-1:0] corner2_x;
    logic signed [COORD_WIDTH-1:0] corner2_y;
    logic signed [COORD_WIDTH-1:0] corner2_z;
    logic signed [15:0]            given_normal_x;
    logic signed [15:0]            given_normal_y;
    logic signed [15:0]            given_normal_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] face_normal_x;
    logic signed [15:0] face_normal_y;
    logic signed [15:0] face_normal_z;
    logic [7:0]         lit_red;
    logic [7:0]         lit_green;
    logic [7:0]         lit_blue;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic [15:0] light_x;
    logic [15:0] light_y;
    logic [15:0] light_z;
    logic [15:0] ambient;
    logic [15:0] diffuse;
    logic [23:0] base_color;
  } cfg_t;

  typedef struct packed {
    logic             use_given;
    logic [2:0][15:0] given;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [2:0]          neg;
    logic [2:0][M_W-1:0] m;
  } geo_t;

  typedef struct packed {
    side_t      side;
    logic [2:0] neg;
    logic       deg;
  } div_tag_t;

endpackage

[rtl/core/flat_shade_face_color_top.sv]
// top level of the flat shading face color block
//
// Takes one triangle word per cycle while in_stall is low and returns one
// shaded face word per triangle, in order: 7 stages of edge and cross product
// arithmetic, 32 square root stages (one root bit each), 15 divider stages
// (one quotient bit each, three lanes) and 5 shading stages, the last being
// the output register. The whole pipeline holds while an output word waits
// under stall. A nonzero stored normal passes unchanged; a zero cross product
// yields a zero normal with degenerate set. The user must write configuration
// via cfg_we/cfg_index/cfg_data with no triangle in flight; it is not enforced.
module flat_shade_face_color_top import fsfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t cfg;
  logic en;

  logic             sum_valid;
  logic [SUM_W-1:0] sum;
  geo_t             geo;
  logic             root_valid;
  logic [LEN_W-1:0] root;
  geo_t             root_geo;
  div_tag_t         dtag_in, dtag_out;
  logic             q_valid;
  logic [2:0][Q_W-1:0] q;
  logic [2:0][15:0] normal;

  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x    <= RST_LIGHT_X;
      cfg.light_y    <= RST_LIGHT_Y;
      cfg.light_z    <= RST_LIGHT_Z;
      cfg.ambient    <= RST_AMBIENT;
      cfg.diffuse    <= RST_DIFFUSE;
      cfg.base_color <= RST_BASE_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIGHT_X:    cfg.light_x    <= cfg_data[15:0];
        CFG_LIGHT_Y:    cfg.light_y    <= cfg_data[15:0];
        CFG_LIGHT_Z:    cfg.light_z    <= cfg_data[15:0];
        CFG_AMBIENT:    cfg.ambient    <= cfg_data[15:0];
        CFG_DIFFUSE:    cfg.diffuse    <= cfg_data[15:0];
        CFG_BASE_COLOR: cfg.base_color <= cfg_data;
        default: ;
      endcase
    end
  end

  fsfc_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .sum_valid (sum_valid),
    .sum       (sum),
    .geo       (geo)
  );

  fsfc_sqrt #(.TAG_W($bits(geo_t))) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sum_valid),
    .radicand   (sum),
    .in_tag     (geo),
    .root_valid (root_valid),
    .root       (root),
    .out_tag    (root_geo)
  );

  always_comb begin
    dtag_in.side = root_geo.side;
    dtag_in.neg  = root_geo.neg;
    dtag_in.deg  = (root == '0);
  end

  fsfc_div #(.TAG_W($bits(div_tag_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (root_valid),
    .len      (root),
    .m        (root_geo.m),
    .in_tag   (dtag_in),
    .q_valid  (q_valid),
    .q        (q),
    .out_tag  (dtag_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dtag_out.side.use_given) begin
        normal[i] = dtag_out.side.given[i];
      end else if (dtag_out.deg) begin
        normal[i] = '0;
      end else begin
        normal[i] = dtag_out.neg[i] ? 16'(-16'(q[i])) : 16'(q[i]);
      end
    end
  end

  fsfc_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .normal    (normal),
    .deg       (~dtag_out.side.use_given & dtag_out.deg),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

[rtl/core/fsfc_cross.sv]
// edge vectors, scaled cross product and its sum of squares
module fsfc_cross import fsfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  in_t              in_word,
  output logic             sum_valid,
  output logic [SUM_W-1:0] sum,
  output geo_t             geo
);

  logic [6:0] v;
  side_t side1, side2, side3, side4;
  geo_t  geo5, geo6;

  logic signed [EDGE_W-1:0]  e [6];
  logic signed [SEDGE_W-1:0] se [6];
  logic signed [PROD_W-1:0]  p [6];
  logic signed [CROSS_W-1:0] x [3];
  logic [SQ_W-1:0]           sq [3];

  logic [EDGE_W-1:0]      emag [6];
  logic [EDGE_W-1:0]      eor;
  logic [SH_W-1:0]        esh;
  logic [SEDGE_MAG_W-1:0] escaled [6];
  logic [CMAG_W-1:0]      cmag [3];
  logic [CMAG_W-1:0]      cor;
  logic [SH_W-1:0]        csh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e[0] <= EDGE_W'(in_word.corner1_x) - EDGE_W'(in_word.corner0_x);
      e[1] <= EDGE_W'(in_word.corner1_y) - EDGE_W'(in_word.corner0_y);
      e[2] <= EDGE_W'(in_word.corner1_z) - EDGE_W'(in_word.corner0_z);
      e[3] <= EDGE_W'(in_word.corner2_x) - EDGE_W'(in_word.corner0_x);
      e[4] <= EDGE_W'(in_word.corner2_y) - EDGE_W'(in_word.corner0_y);
      e[5] <= EDGE_W'(in_word.corner2_z) - EDGE_W'(in_word.corner0_z);
      side1.use_given <= (in_word.given_normal_x == '0) && (in_word.given_normal_y == '0)
                         && (in_word.given_normal_z == '0) ? 1'b0 : 1'b1;
      side1.given <= {in_word.given_normal_z, in_word.given_normal_y, in_word.given_normal_x};
    end
  end

  // edge scaling on magnitude
  always_comb begin
    eor = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e[i][EDGE_W-1] ? EDGE_W'(-e[i]) : EDGE_W'(e[i]);
      eor = eor | emag[i];
    end
    esh = '0;
    for (int b = SEDGE_MAG_W; b < EDGE_W; b++) begin
      if (eor[b]) begin
        esh = SH_W'(b - SEDGE_MAG_W + 1);
      end
    end
    for (int i = 0; i < 6; i++) begin
      escaled[i] = SEDGE_MAG_W'(emag[i] >> esh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        se[i] <= e[i][EDGE_W-1] ? -$signed({1'b0, escaled[i]}) : $signed({1'b0, escaled[i]});
      end
      side2 <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= se[1] * se[5];
      p[1] <= se[2] * se[4];
      p[2] <= se[2] * se[3];
      p[3] <= se[0] * se[5];
      p[4] <= se[0] * se[4];
      p[5] <= se[1] * se[3];
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CROSS_W'(p[0]) - CROSS_W'(p[1]);
      x[1] <= CROSS_W'(p[2]) - CROSS_W'(p[3]);
      x[2] <= CROSS_W'(p[4]) - CROSS_W'(p[5]);
      side4 <= side3;
    end
  end

  // cross scaling on magnitude
  always_comb begin
    cor = '0;
    for (int i = 0; i < 3; i++) begin
      cmag[i] = x[i][CROSS_W-1] ? CMAG_W'(-x[i]) : CMAG_W'(x[i]);
      cor = cor | cmag[i];
    end
    csh = '0;
    for (int b = M_W; b < CMAG_W; b++) begin
      if (cor[b]) begin
        csh = SH_W'(b - M_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        geo5.m[i]   <= M_W'(cmag[i] >> csh);
        geo5.neg[i] <= x[i][CROSS_W-1];
      end
      geo5.side <= side4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= geo5.m[i] * geo5.m[i];
      end
      geo6 <= geo5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      geo <= geo6;
    end
  end

  assign sum_valid = v[6];

endmodule

[rtl/core/fsfc_sqrt.sv]
// pipelined integer square root, one result bit per stage
module fsfc_sqrt import fsfc_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] radicand,
  input  logic [TAG_W-1:0] in_tag,
  output logic             root_valid,
  output logic [LEN_W-1:0] root,
  output logic [TAG_W-1:0] out_tag
);

  logic [SUM_W-1:0] xr [LEN_W+1];
  logic [SUM_W-1:0] rr [LEN_W+1];
  logic [TAG_W-1:0] tg [LEN_W+1];
  logic [LEN_W:0]   v;

  assign xr[0] = radicand;
  assign rr[0] = '0;
  assign tg[0] = in_tag;
  assign v[0]  = in_valid;

  for (genvar k = 0; k < LEN_W; k++) begin : g_step
    localparam logic [SUM_W-1:0] Bit = SUM_W'(1) << (2 * (LEN_W - 1 - k));
    logic [SUM_W-1:0] trial;
    logic             take;

    assign trial = rr[k] + Bit;
    assign take  = xr[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[k+1] <= take ? xr[k] - trial : xr[k];
        rr[k+1] <= take ? (rr[k] >> 1) + Bit : rr[k] >> 1;
        tg[k+1] <= tg[k];
      end
    end
  end

  assign root_valid = v[LEN_W];
  assign root       = rr[LEN_W][LEN_W-1:0];
  assign out_tag    = tg[LEN_W];

endmodule

[rtl/core/fsfc_div.sv]
// three-lane pipelined rounded divider for normal components
module fsfc_div import fsfc_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LEN_W-1:0]    len,
  input  logic [2:0][M_W-1:0] m,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                q_valid,
  output logic [2:0][Q_W-1:0] q,
  output logic [TAG_W-1:0]    out_tag
);

  logic [2:0][REM_W-1:0] rem [Q_W+1];
  logic [2:0][Q_W-1:0]   qt  [Q_W+1];
  logic [LEN_W-1:0]      dv  [Q_W+1];
  logic [TAG_W-1:0]      tg  [Q_W+1];
  logic [Q_W:0]          v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = (REM_W'(m[i]) << NORM_SHIFT) + REM_W'(len >> 1);
    end
  end
  assign qt[0] = '0;
  assign dv[0] = len;
  assign tg[0] = in_tag;
  assign v[0]  = in_valid;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int Sh = Q_W - 1 - k;
    logic [REM_W-1:0] d;

    assign d = REM_W'(dv[k]) << Sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem[k+1][i] <= rem[k][i] >= d ? rem[k][i] - d : rem[k][i];
          qt[k+1][i]  <= qt[k][i] | (rem[k][i] >= d ? Q_W'(1) << Sh : '0);
        end
        dv[k+1] <= dv[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign q_valid = v[Q_W];
  assign q       = qt[Q_W];
  assign out_tag = tg[Q_W];

endmodule

[rtl/core/fsfc_shade.sv]
// lambert intensity and color scaling, ending in the output register
module fsfc_shade import fsfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][15:0] normal,
  input  logic             deg,
  input  cfg_t             cfg,
  output logic             out_valid,
  output out_t             out_word
);

  logic [4:0] v;
  logic [2:0][15:0] n1, n2, n3, n4;
  logic d1, d2, d3, d4;
  logic signed [31:0] pr [3];
  logic signed [33:0] dot;
  logic [48:0]        dprod;
  logic [15:0]        inten;
  logic [32:0]        ad;
  logic [21:0]        isum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= $signed(normal[0]) * $signed(cfg.light_x);
      pr[1] <= $signed(normal[1]) * $signed(cfg.light_y);
      pr[2] <= $signed(normal[2]) * $signed(cfg.light_z);
      n1 <= normal;
      d1 <= deg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot <= 34'(pr[0]) + 34'(pr[1]) + 34'(pr[2]);
      n2 <= n1;
      d2 <= d1;
    end
  end

  assign ad = dot[33] ? 33'(-dot) : 33'(dot);

  always_ff @(posedge clk) begin
    if (en) begin
      dprod <= 49'(cfg.diffuse) * 49'(ad);
      n3 <= n2;
      d3 <= d2;
    end
  end

  assign isum = 22'(cfg.ambient) + 22'(dprod[48:28]);

  always_ff @(posedge clk) begin
    if (en) begin
      inten <= isum > 22'(LEVEL_ONE) ? LEVEL_ONE : isum[15:0];
      n4 <= n3;
      d4 <= d3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.face_normal_x <= n4[0];
      out_word.face_normal_y <= n4[1];
      out_word.face_normal_z <= n4[2];
      out_word.lit_red   <= 8'((24'(cfg.base_color[7:0]) * 24'(inten)) >> 15);
      out_word.lit_green <= 8'((24'(cfg.base_color[15:8]) * 24'(inten)) >> 15);
      out_word.lit_blue  <= 8'((24'(cfg.base_color[23:16]) * 24'(inten)) >> 15);
      out_word.degenerate <= d4;
    end
  end

  assign out_valid = v[4];

endmodule
